>>> design/dacc_pkg.sv
// Shared types, instruction codes and status codes for the decimal accumulator machine.
package dacc_pkg;

   // Item modes carried on req_tuser
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_EXEC    = 2'd1;
   localparam logic [1:0] MODE_PEEK    = 2'd2;
   localparam logic [1:0] MODE_RESTART = 2'd3;

   // Instruction opcodes
   localparam logic [6:0] OP_NOP    = 7'd0;
   localparam logic [6:0] OP_READ   = 7'd10;
   localparam logic [6:0] OP_WRITE  = 7'd11;
   localparam logic [6:0] OP_LOAD   = 7'd20;
   localparam logic [6:0] OP_STORE  = 7'd21;
   localparam logic [6:0] OP_ADD    = 7'd30;
   localparam logic [6:0] OP_SUB    = 7'd31;
   localparam logic [6:0] OP_DIV    = 7'd32;
   localparam logic [6:0] OP_MUL    = 7'd33;
   localparam logic [6:0] OP_BR     = 7'd40;
   localparam logic [6:0] OP_BRNEG  = 7'd41;
   localparam logic [6:0] OP_BRZERO = 7'd42;
   localparam logic [6:0] OP_HALT   = 7'd43;

   // Result status codes
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_BAD_LOAD = 3'd1;
   localparam logic [2:0] STS_OVERFLOW = 3'd2;
   localparam logic [2:0] STS_DIV_ZERO = 3'd3;
   localparam logic [2:0] STS_BAD_OP   = 3'd4;
   localparam logic [2:0] STS_HALTED   = 3'd5;
   localparam logic [2:0] STS_RAN_OFF  = 3'd6;
   localparam logic [2:0] STS_STOPPED  = 3'd7;

   localparam int WORD_MAX    = 9999;
   localparam int DEC_BASE    = 100;
   // x / 100 == (x * 5243) >> 19 for every x below 43699
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int MAG_W       = 14;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   typedef struct packed {
      logic [2:0]         pad;
      logic signed [14:0] read_value;
      logic signed [14:0] load_word;
      logic [6:0]         address;
   } req_type;

   typedef struct packed {
      logic               pad;
      logic               running;
      logic signed [14:0] peek_data;
      logic signed [14:0] print_value;
      logic               print_valid;
      logic [6:0]         operand_done;
      logic [6:0]         opcode_done;
      logic signed [14:0] accumulator_value;
      logic [6:0]         program_counter;
      logic [2:0]         status;
   } rsp_type;

   function automatic logic opcode_known(input logic [6:0] op);
      logic known;
      case (op)
         OP_NOP, OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
         OP_DIV, OP_MUL, OP_BR, OP_BRNEG, OP_BRZERO, OP_HALT: known = 1'b1;
         default: known = 1'b0;
      endcase
      return known;
   endfunction

endpackage

>>> design/decimal_accumulator_cpu.sv
// Decimal accumulator machine: word memory, instruction sequencer and arithmetic units.
//
// One transaction on req is one item: req_tuser selects load, execute, peek or restart, and
// exactly one result transaction follows on rsp. Items are handled one at a time: ready is
// low from the accepting edge until the edge that registers the result. Restart, and
// execute while stopped or with the counter outside memory, go straight to the result;
// peek does one synchronous memory read, load a decimal split of the word, then a write,
// an ordinary instruction fetch, decode with operand read and execute, multiply adds one
// registered multiply before the range check, and divide runs the 14-step restoring
// divider. Memory comes up cleared through one valid bit per word, so there is no clearing
// pass after reset. A result waiting in the rsp register does not hold off the next item;
// that item stalls in its done state until the waiting result is taken.
module decimal_accumulator_cpu #(
   parameter int MEM_WORDS = 100
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // address[6:0], load_word[21:7], read_value[36:22], zero fill
   input  logic [dacc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode[1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[2:0], program_counter[9:3], accumulator_value[24:10], opcode_done[31:25],
   // operand_done[38:32], print_valid[39], print_value[54:40], peek_data[69:55],
   // running[70], zero fill
   output logic [dacc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import dacc_pkg::*;

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [6:0] MEM_LIMIT = 7'(MEM_WORDS);
   localparam logic [3:0] DIV_LAST = 4'(MAG_W - 1);

   localparam logic signed [14:0] ACC_MAX  = 15'(WORD_MAX);
   localparam logic signed [14:0] ACC_MIN  = -ACC_MAX;
   localparam logic signed [15:0] SUM_MAX  = 16'(WORD_MAX);
   localparam logic signed [15:0] SUM_MIN  = -SUM_MAX;
   localparam logic signed [29:0] PROD_MAX = 30'(WORD_MAX);
   localparam logic signed [29:0] PROD_MIN = -PROD_MAX;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LSPLIT  = 4'd1;
   localparam logic [3:0] S_LOAD    = 4'd2;
   localparam logic [3:0] S_PEEK    = 4'd3;
   localparam logic [3:0] S_FETCH   = 4'd4;
   localparam logic [3:0] S_DECODE  = 4'd5;
   localparam logic [3:0] S_EXEC    = 4'd6;
   localparam logic [3:0] S_MUL     = 4'd7;
   localparam logic [3:0] S_DIV     = 4'd8;
   localparam logic [3:0] S_DIVFIN  = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   req_type req_in;
   assign req_in = req_tdata;

   // Word memory
   logic signed [14:0] mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] vld_ff;
   logic signed [14:0] rd_data_ff;
   logic               rd_vld_ff;
   logic [6:0]         rd_addr;
   logic               wr_en;
   logic [6:0]         wr_addr;
   logic signed [14:0] wr_data;
   logic               rd_inrange, wr_inrange;
   logic [AW-1:0]      rd_idx, wr_idx;
   logic signed [14:0] rd_value;

   // Architectural and sequencing state
   logic [3:0]         state_ff, state_in;
   logic [6:0]         pc_ff, pc_in;
   logic signed [14:0] acc_ff, acc_in;
   logic [2:0]         stop_ff, stop_in;
   logic [6:0]         addr_ff, addr_in;
   logic signed [14:0] lw_ff, lw_in;
   logic signed [14:0] rv_ff, rv_in;
   logic [13:0]        split_x_ff, split_x_in;
   logic [6:0]         quot_ff, quot_in;
   logic               word_neg_ff, word_neg_in;
   logic [6:0]         op_ff, op_in;
   logic [6:0]         opnd_ff, opnd_in;
   logic signed [29:0] prod_ff, prod_in;
   logic [13:0]        div_rem_ff, div_rem_in;
   logic [13:0]        div_quo_ff, div_quo_in;
   logic [13:0]        div_den_ff, div_den_in;
   logic [3:0]         div_cnt_ff, div_cnt_in;
   logic               div_neg_ff, div_neg_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [6:0]         res_op_ff, res_op_in;
   logic [6:0]         res_opnd_ff, res_opnd_in;
   logic               res_pv_ff, res_pv_in;
   logic signed [14:0] res_pval_ff, res_pval_in;
   logic signed [14:0] res_peek_ff, res_peek_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath helpers
   logic [13:0]        split_src;
   logic [26:0]        split_prod;
   logic [6:0]         split_quot;
   logic [13:0]        dec_rem_full;
   logic [6:0]         dec_rem;
   logic [6:0]         pc_inc;
   logic signed [15:0] sum_add, sum_sub;
   logic signed [14:0] rv_sat;
   logic [13:0]        acc_mag, mem_mag;
   logic [14:0]        div_shift, div_diff;
   logic               div_ge;
   logic signed [14:0] div_q;
   logic               lw_ok;
   logic               fin_en;
   logic [2:0]         fin_err;
   logic [6:0]         fin_next;

   assign rd_inrange = (rd_addr < MEM_LIMIT);
   assign wr_inrange = (wr_addr < MEM_LIMIT);
   assign rd_idx     = rd_addr[AW-1:0];
   assign wr_idx     = wr_addr[AW-1:0];
   assign rd_value   = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (wr_en && wr_inrange) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en && wr_inrange) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         rd_vld_ff <= rd_inrange && vld_ff[rd_idx];
      end
   end

   // Decimal split: quotient by reciprocal multiply, remainder from the registered quotient
   assign split_src    = (state_ff == S_LSPLIT) ? lw_ff[13:0] : rd_value[13:0];
   assign split_prod   = 27'(split_src) * 27'(RECIP_100);
   assign split_quot   = split_prod[RECIP_SHIFT +: 7];
   assign dec_rem_full = split_x_ff - 14'(quot_ff) * 14'(DEC_BASE);
   assign dec_rem      = dec_rem_full[6:0];

   assign pc_inc  = pc_ff + 7'd1;
   assign sum_add = {acc_ff[14], acc_ff} + {rd_value[14], rd_value};
   assign sum_sub = {acc_ff[14], acc_ff} - {rd_value[14], rd_value};
   assign rv_sat  = (rv_ff > ACC_MAX) ? ACC_MAX : ((rv_ff < ACC_MIN) ? ACC_MIN : rv_ff);
   assign acc_mag = acc_ff[14] ? 14'(-acc_ff) : acc_ff[13:0];
   assign mem_mag = rd_value[14] ? 14'(-rd_value) : rd_value[13:0];

   assign div_shift = {div_rem_ff, div_quo_ff[13]};
   assign div_diff  = div_shift - {1'b0, div_den_ff};
   assign div_ge    = (div_shift >= {1'b0, div_den_ff});
   assign div_q     = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});

   assign lw_ok = !lw_ff[14] && (lw_ff <= ACC_MAX) && (addr_ff < MEM_LIMIT) &&
                  (dec_rem < MEM_LIMIT) && opcode_known(quot_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      acc_in        = acc_ff;
      stop_in       = stop_ff;
      addr_in       = addr_ff;
      lw_in         = lw_ff;
      rv_in         = rv_ff;
      split_x_in    = split_x_ff;
      quot_in       = quot_ff;
      word_neg_in   = word_neg_ff;
      op_in         = op_ff;
      opnd_in       = opnd_ff;
      prod_in       = prod_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_den_in    = div_den_ff;
      div_cnt_in    = div_cnt_ff;
      div_neg_in    = div_neg_ff;
      res_status_in = res_status_ff;
      res_op_in     = res_op_ff;
      res_opnd_in   = res_opnd_ff;
      res_pv_in     = res_pv_ff;
      res_pval_in   = res_pval_ff;
      res_peek_in   = res_peek_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rd_addr       = pc_ff;
      wr_en         = 1'b0;
      wr_addr       = opnd_ff;
      wr_data       = acc_ff;
      fin_en        = 1'b0;
      fin_err       = STS_OK;
      fin_next      = pc_inc;

      case (state_ff)
         S_IDLE: begin
            if (req_tuser == MODE_PEEK) begin
               rd_addr = req_in.address;
            end
            if (req_tvalid) begin
               addr_in       = req_in.address;
               lw_in         = req_in.load_word;
               rv_in         = req_in.read_value;
               res_status_in = STS_OK;
               res_op_in     = '0;
               res_opnd_in   = '0;
               res_pv_in     = 1'b0;
               res_pval_in   = '0;
               res_peek_in   = '0;
               case (req_tuser)
                  MODE_LOAD: state_in = S_LSPLIT;
                  MODE_PEEK: state_in = S_PEEK;
                  MODE_RESTART: begin
                     acc_in   = '0;
                     pc_in    = '0;
                     stop_in  = STS_OK;
                     state_in = S_DONE;
                  end
                  default: begin
                     if (stop_ff != STS_OK) begin
                        res_status_in = STS_STOPPED;
                        state_in      = S_DONE;
                     end else if (pc_ff >= MEM_LIMIT) begin
                        stop_in       = STS_RAN_OFF;
                        res_status_in = STS_RAN_OFF;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
               endcase
            end
         end

         S_LSPLIT: begin
            split_x_in = lw_ff[13:0];
            quot_in    = split_quot;
            state_in   = S_LOAD;
         end

         S_LOAD: begin
            wr_addr = addr_ff;
            wr_data = lw_ff;
            if (lw_ok) begin
               wr_en = 1'b1;
            end else begin
               res_status_in = STS_BAD_LOAD;
            end
            state_in = S_DONE;
         end

         S_PEEK: begin
            res_peek_in = rd_value;
            state_in    = S_DONE;
         end

         S_FETCH: begin
            split_x_in  = rd_value[13:0];
            quot_in     = split_quot;
            word_neg_in = rd_value[14];
            state_in    = S_DECODE;
         end

         S_DECODE: begin
            rd_addr = dec_rem;
            op_in   = quot_ff;
            opnd_in = dec_rem;
            if (word_neg_ff) begin
               fin_en  = 1'b1;
               fin_err = STS_BAD_OP;
            end else begin
               res_op_in   = quot_ff;
               res_opnd_in = dec_rem;
               if (!opcode_known(quot_ff)) begin
                  fin_en  = 1'b1;
                  fin_err = STS_BAD_OP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            case (op_ff)
               OP_READ: begin
                  wr_en   = 1'b1;
                  wr_data = rv_sat;
                  fin_en  = 1'b1;
               end
               OP_WRITE: begin
                  res_pv_in   = 1'b1;
                  res_pval_in = rd_value;
                  fin_en      = 1'b1;
               end
               OP_LOAD: begin
                  acc_in = rd_value;
                  fin_en = 1'b1;
               end
               OP_STORE: begin
                  wr_en  = 1'b1;
                  fin_en = 1'b1;
               end
               OP_ADD: begin
                  fin_en = 1'b1;
                  if (sum_add > SUM_MAX || sum_add < SUM_MIN) begin
                     fin_err = STS_OVERFLOW;
                  end else begin
                     acc_in = sum_add[14:0];
                  end
               end
               OP_SUB: begin
                  fin_en = 1'b1;
                  if (sum_sub > SUM_MAX || sum_sub < SUM_MIN) begin
                     fin_err = STS_OVERFLOW;
                  end else begin
                     acc_in = sum_sub[14:0];
                  end
               end
               OP_MUL: begin
                  prod_in  = 30'(acc_ff) * 30'(rd_value);
                  state_in = S_MUL;
               end
               OP_DIV: begin
                  if (rd_value == '0) begin
                     fin_en  = 1'b1;
                     fin_err = STS_DIV_ZERO;
                  end else begin
                     div_rem_in = '0;
                     div_quo_in = acc_mag;
                     div_den_in = mem_mag;
                     div_cnt_in = '0;
                     div_neg_in = acc_ff[14] ^ rd_value[14];
                     state_in   = S_DIV;
                  end
               end
               OP_BR: begin
                  fin_en   = 1'b1;
                  fin_next = opnd_ff;
               end
               OP_BRNEG: begin
                  fin_en = 1'b1;
                  if (acc_ff[14]) begin
                     fin_next = opnd_ff;
                  end
               end
               OP_BRZERO: begin
                  fin_en = 1'b1;
                  if (acc_ff == '0) begin
                     fin_next = opnd_ff;
                  end
               end
               OP_HALT: begin
                  fin_en  = 1'b1;
                  fin_err = STS_HALTED;
               end
               default: begin
                  fin_en = 1'b1;
               end
            endcase
         end

         S_MUL: begin
            fin_en = 1'b1;
            if (prod_ff > PROD_MAX || prod_ff < PROD_MIN) begin
               fin_err = STS_OVERFLOW;
            end else begin
               acc_in = prod_ff[14:0];
            end
         end

         S_DIV: begin
            div_rem_in = div_ge ? div_diff[13:0] : div_shift[13:0];
            div_quo_in = {div_quo_ff[12:0], div_ge};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = S_DIVFIN;
            end
         end

         S_DIVFIN: begin
            acc_in = div_q;
            fin_en = 1'b1;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.pad               = 1'b0;
               rsp_in.running           = (stop_ff == STS_OK);
               rsp_in.peek_data         = res_peek_ff;
               rsp_in.print_value       = res_pval_ff;
               rsp_in.print_valid       = res_pv_ff;
               rsp_in.operand_done      = res_opnd_ff;
               rsp_in.opcode_done       = res_op_ff;
               rsp_in.accumulator_value = acc_ff;
               rsp_in.program_counter   = pc_ff;
               rsp_in.status            = res_status_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Retire the instruction: errors stop the machine, otherwise advance the counter and stop if it leaves memory
      if (fin_en) begin
         if (fin_err != STS_OK) begin
            stop_in       = fin_err;
            res_status_in = fin_err;
         end else begin
            pc_in = fin_next;
            if (fin_next >= MEM_LIMIT) begin
               stop_in       = STS_RAN_OFF;
               res_status_in = STS_RAN_OFF;
            end
         end
         state_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         stop_ff      <= STS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      lw_ff         <= lw_in;
      rv_ff         <= rv_in;
      split_x_ff    <= split_x_in;
      quot_ff       <= quot_in;
      word_neg_ff   <= word_neg_in;
      op_ff         <= op_in;
      opnd_ff       <= opnd_in;
      prod_ff       <= prod_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_den_ff    <= div_den_in;
      div_cnt_ff    <= div_cnt_in;
      div_neg_ff    <= div_neg_in;
      res_status_ff <= res_status_in;
      res_op_ff     <= res_op_in;
      res_opnd_ff   <= res_opnd_in;
      res_pv_ff     <= res_pv_in;
      res_pval_ff   <= res_pval_in;
      res_peek_ff   <= res_peek_in;
      rsp_ff        <= rsp_in;
   end

   // Every error or stop status other than a bad load reports a stopped machine
   a_stop_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == STS_OVERFLOW || rsp_ff.status == STS_DIV_ZERO ||
                       rsp_ff.status == STS_BAD_OP || rsp_ff.status == STS_HALTED ||
                       rsp_ff.status == STS_RAN_OFF || rsp_ff.status == STS_STOPPED)
      |-> !rsp_ff.running)
      else $error("error status reported while machine still running");

   // A running machine always points inside memory
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (stop_ff == STS_OK) |-> (pc_ff < MEM_LIMIT))
      else $error("instruction counter out of memory while running");

   // Divider partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_rem_ff < div_den_ff))
      else $error("divider remainder not below divisor");

   // One transaction in flight: acceptance drops ready on the next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction accepted while one is in progress");

endmodule
